### hdl/nearest_neighbor_downscaler_macros.svh
// Assertion macros used by the checker module of the downscaler.
`ifndef NEAREST_NEIGHBOR_DOWNSCALER_MACROS_SVH
`define NEAREST_NEIGHBOR_DOWNSCALER_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define NNDS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define NNDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/nnds_pkg.sv
package nnds_pkg;

    localparam int MAX_DIM_LOG2 = 8;
    localparam int MAX_DIM      = 1 << MAX_DIM_LOG2;
    localparam int MAX_SOURCE   = 8192;

    localparam int SIZE_W = 14;
    localparam int POS_W  = 13;
    localparam int PH_W   = $clog2(MAX_DIM * MAX_SOURCE) + 1;
    localparam int NK_W   = PH_W - MAX_DIM_LOG2;
    localparam int PIX_W  = 8;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = CFG_IDX_W'(1);

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             eol;
        logic             eof;
    } t_pix;

    typedef struct packed {
        logic valid;
        t_pix pix;
    } t_slot;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > SIZE_W'(MAX_SOURCE)) begin
            r = SIZE_W'(MAX_SOURCE);
        end
        return r;
    endfunction

    function automatic logic [SIZE_W-1:0] max3(input logic [SIZE_W-1:0] a,
                                               input logic [SIZE_W-1:0] b);
        logic [SIZE_W-1:0] r;
        r = (a > b) ? a : b;
        if (r < SIZE_W'(MAX_DIM)) begin
            r = SIZE_W'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

### hdl/nearest_neighbor_downscaler.sv
// Channel    Direction  Handshake           Payload
// pixel in   input      i_valid / o_stall   i_red_in, i_green_in, i_blue_in
// pixel out  output     o_valid / i_stall   o_red_out, o_green_out, o_blue_out, o_end_of_line,
//                                           o_end_of_frame
// config     input      i_cfg_we            i_cfg_idx, i_cfg_data
//
// One source pixel is accepted every clock while o_stall is low; the front classifier decides in that cycle.
// A kept pixel reaches the output through a four-entry queue and the output register.
// o_stall rises only while the queue is full because the output side is stalled.
// Reset is synchronous and leaves a 256 by 256 source size.
module nearest_neighbor_downscaler
    import nnds_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SIZE_W-1:0]    i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [PIX_W-1:0]     i_red_in,
    input  logic [PIX_W-1:0]     i_green_in,
    input  logic [PIX_W-1:0]     i_blue_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [PIX_W-1:0]     o_red_out,
    output logic [PIX_W-1:0]     o_green_out,
    output logic [PIX_W-1:0]     o_blue_out,
    output logic                 o_end_of_line,
    output logic                 o_end_of_frame
);

    t_slot push, head;
    logic  q_full, pop;

    nnds_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_red_in   (i_red_in),
        .i_green_in (i_green_in),
        .i_blue_in  (i_blue_in),
        .i_q_full   (q_full),
        .o_push     (push)
    );

    nnds_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_head  (head)
    );

    nnds_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_red_out      (o_red_out),
        .o_green_out    (o_green_out),
        .o_blue_out     (o_blue_out),
        .o_end_of_line  (o_end_of_line),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule

### hdl/nnds_front.sv
module nnds_front
    import nnds_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SIZE_W-1:0]    i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [PIX_W-1:0]     i_red_in,
    input  logic [PIX_W-1:0]     i_green_in,
    input  logic [PIX_W-1:0]     i_blue_in,
    input  logic                 i_q_full,
    output t_slot                o_push
);

    logic [SIZE_W-1:0] r_eff_w, r_eff_h, r_m;
    logic [POS_W-1:0]  r_src_col, r_src_row;
    logic [PH_W-1:0]   r_col_ph, r_row_ph;

    logic [SIZE_W-1:0] n_eff, n_m;
    logic              accept, restart;
    logic [PH_W:0]     m_x, w_lim, h_lim, col_nx, row_nx;
    logic [PH_W+1:0]   col_nx2, row_nx2;
    logic              col_ok, row_ok, col_kept, row_kept, eol, eof;
    logic              row_end, frame_end;

    assign accept  = i_valid && !i_q_full;
    assign o_stall = i_q_full;

    assign n_eff   = eff_size(i_cfg_data);
    assign n_m     = (i_cfg_idx == CFG_WIDTH) ? max3(n_eff, r_eff_h) : max3(r_eff_w, n_eff);
    assign restart = i_cfg_we && (i_cfg_idx == CFG_WIDTH || i_cfg_idx == CFG_HEIGHT);

    assign m_x   = (PH_W+1)'(r_m);
    assign w_lim = (PH_W+1)'({r_eff_w, {MAX_DIM_LOG2{1'b0}}});
    assign h_lim = (PH_W+1)'({r_eff_h, {MAX_DIM_LOG2{1'b0}}});

    assign col_nx  = (PH_W+1)'(r_col_ph) + m_x;
    assign row_nx  = (PH_W+1)'(r_row_ph) + m_x;
    assign col_nx2 = (PH_W+2)'(col_nx) + (PH_W+2)'(m_x);
    assign row_nx2 = (PH_W+2)'(row_nx) + (PH_W+2)'(m_x);

    assign col_ok   = col_nx <= w_lim;
    assign row_ok   = row_nx <= h_lim;
    assign col_kept = col_ok && (r_col_ph[PH_W-1:MAX_DIM_LOG2] == NK_W'(r_src_col));
    assign row_kept = row_ok && (r_row_ph[PH_W-1:MAX_DIM_LOG2] == NK_W'(r_src_row));
    assign eol      = col_nx2 > (PH_W+2)'(w_lim);
    assign eof      = eol && (row_nx2 > (PH_W+2)'(h_lim));

    assign row_end   = (SIZE_W'(r_src_col) + SIZE_W'(1)) >= r_eff_w;
    assign frame_end = (SIZE_W'(r_src_row) + SIZE_W'(1)) >= r_eff_h;

    always_comb begin
        o_push.valid     = accept && row_kept && col_kept;
        o_push.pix.red   = i_red_in;
        o_push.pix.green = i_green_in;
        o_push.pix.blue  = i_blue_in;
        o_push.pix.eol   = eol;
        o_push.pix.eof   = eof;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w   <= SIZE_W'(MAX_DIM);
            r_eff_h   <= SIZE_W'(MAX_DIM);
            r_m       <= SIZE_W'(MAX_DIM);
            r_src_col <= '0;
            r_src_row <= '0;
            r_col_ph  <= '0;
            r_row_ph  <= '0;
        end else if (restart) begin
            if (i_cfg_idx == CFG_WIDTH) begin
                r_eff_w <= n_eff;
            end else begin
                r_eff_h <= n_eff;
            end
            r_m       <= n_m;
            r_src_col <= '0;
            r_src_row <= '0;
            r_col_ph  <= '0;
            r_row_ph  <= '0;
        end else if (accept) begin
            if (row_end) begin
                r_src_col <= '0;
                r_col_ph  <= '0;
                if (frame_end) begin
                    r_src_row <= '0;
                    r_row_ph  <= '0;
                end else begin
                    r_src_row <= r_src_row + POS_W'(1);
                    if (row_kept) begin
                        r_row_ph <= row_nx[PH_W-1:0];
                    end
                end
            end else begin
                r_src_col <= r_src_col + POS_W'(1);
                if (row_kept && col_kept) begin
                    r_col_ph <= col_nx[PH_W-1:0];
                end
            end
        end
    end

endmodule

### hdl/nnds_queue.sv
module nnds_queue
    import nnds_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_slot i_push,
    output logic  o_full,
    input  logic  i_pop,
    output t_slot o_head
);

    t_pix            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_AW:0]   r_count;

    logic do_push, do_pop;

    assign o_full      = r_count == (Q_AW+1)'(Q_DEPTH);
    assign do_push     = i_push.valid && !o_full;
    assign do_pop      = i_pop && (r_count != '0);
    assign o_head.valid = r_count != '0;
    assign o_head.pix   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (Q_AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (Q_AW+1)'(1);
            end
        end
    end

endmodule

### hdl/nnds_back.sv
module nnds_back
    import nnds_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_slot            i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [PIX_W-1:0] o_red_out,
    output logic [PIX_W-1:0] o_green_out,
    output logic [PIX_W-1:0] o_blue_out,
    output logic             o_end_of_line,
    output logic             o_end_of_frame
);

    logic r_valid;
    t_pix r_pix;
    logic load;

    assign load  = i_head.valid && (!r_valid || !i_stall);
    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pix <= i_head.pix;
        end
    end

    assign o_valid        = r_valid;
    assign o_red_out      = r_pix.red;
    assign o_green_out    = r_pix.green;
    assign o_blue_out     = r_pix.blue;
    assign o_end_of_line  = r_pix.eol;
    assign o_end_of_frame = r_pix.eof;

endmodule

### hdl/nnds_checker.sv
`include "nearest_neighbor_downscaler_macros.svh"

module nnds_checker
    import nnds_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_stall,
    input logic             o_valid,
    input logic             i_stall,
    input logic [PIX_W-1:0] o_red_out,
    input logic [PIX_W-1:0] o_green_out,
    input logic [PIX_W-1:0] o_blue_out,
    input logic             o_end_of_line,
    input logic             o_end_of_frame
);

    logic [3*PIX_W+1:0] out_word;

    assign out_word = {o_red_out, o_green_out, o_blue_out, o_end_of_line, o_end_of_frame};

    `NNDS_ASSERT_NOW(a_idle_after_reset, $rose(i_rst_n), !o_valid && !o_stall, "busy after reset")
    `NNDS_ASSERT_NOW(a_eof_is_eol, o_valid && o_end_of_frame, o_end_of_line, "eof without eol")
    `NNDS_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(out_word), "output changed")
    `NNDS_ASSERT_NEXT(a_no_stall_when_drained, !o_valid && !o_stall, !o_stall, "stall when drained")

endmodule

bind nearest_neighbor_downscaler nnds_checker u_nnds_checker (.*);
